/* design/sorted_topk_unique_key_table_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted top-k key table
// Shorthand for clocked, reset-qualified concurrent assertions on clk/arst_n.
// ----------------------------------------------------------------------------
`ifndef SORTED_TOPK_UNIQUE_KEY_TABLE_CORE_ASSERT_SVH
`define SORTED_TOPK_UNIQUE_KEY_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define STKT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define STKT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* design/stkt_pkg.sv */
// ----------------------------------------------------------------------------
// stkt_pkg
// Shared types and constants for the sorted top-k key table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stkt_pkg;

	localparam int TABLE_SLOTS = 8;
	localparam int IDX_W       = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int NAME_BYTES  = 15;
	localparam int NAME_W      = 8 * NAME_BYTES;
	localparam int SCORE_W     = 20;

	localparam logic [SCORE_W-1:0] EMPTY_SCORE = 20'd999999;
	// "---" zero padded, first byte in the low bits
	localparam logic [NAME_W-1:0]  EMPTY_NAME  = 120'h2D2D2D;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_READ   = 1'b1;

	typedef struct packed {
		logic [NAME_W-1:0]  name;
		logic [SCORE_W-1:0] score;
	} stkt_entry_t;

	localparam stkt_entry_t EMPTY_ENTRY = '{name: EMPTY_NAME, score: EMPTY_SCORE};

	// broadcast to every cell
	typedef struct packed {
		logic               remove;
		logic               place;
		logic [NAME_W-1:0]  name;
		logic [SCORE_W-1:0] score;
	} stkt_cmd_t;

	// rippled from cell to cell, slot 0 first
	typedef struct packed {
		logic             found;
		logic             abort;
		logic             placed;
		logic [IDX_W-1:0] pos;
	} stkt_chain_t;

endpackage

/* design/stkt_norm.sv */
// ----------------------------------------------------------------------------
// stkt_norm
// Clears every name byte after the first zero byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stkt_norm (
	input  logic [63:0]                 name_head,
	input  logic [55:0]                 name_tail,
	output logic [stkt_pkg::NAME_W-1:0] name
);

	logic [stkt_pkg::NAME_W-1:0] raw;

	assign raw = {name_tail, name_head};

	always_comb begin
		logic ended;
		ended = 1'b0;
		name  = '0;
		for (int i = 0; i < stkt_pkg::NAME_BYTES; i++) begin
			if (raw[8*i +: 8] == 8'd0) begin
				ended = 1'b1;
			end
			if (!ended) begin
				name[8*i +: 8] = raw[8*i +: 8];
			end
		end
	end

endmodule

/* design/stkt_cell.sv */
// ----------------------------------------------------------------------------
// stkt_cell
// One table slot: holds an entry, shifts up on removal, down on placement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stkt_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stkt_pkg::stkt_cmd_t   cmd,
	input  stkt_pkg::stkt_entry_t prev_entry,
	input  stkt_pkg::stkt_entry_t next_entry,
	input  stkt_pkg::stkt_chain_t chain_in,
	output stkt_pkg::stkt_entry_t entry,
	output stkt_pkg::stkt_chain_t chain_out
);

	stkt_pkg::stkt_entry_t entry_q;
	logic                  match;
	logic                  worse;
	logic                  shift_up;

	assign entry = entry_q;

	// only occupied slots take part in the name match
	assign match = (entry_q.score < stkt_pkg::EMPTY_SCORE) && (entry_q.name == cmd.name);
	assign worse = cmd.score < entry_q.score;

	always_comb begin
		chain_out.found  = chain_in.found | match;
		chain_out.abort  = chain_in.found ? chain_in.abort
		                                  : (match && (cmd.score >= entry_q.score));
		chain_out.placed = chain_in.placed | worse;
		chain_out.pos    = chain_out.placed ? chain_in.pos
		                                    : stkt_pkg::IDX_W'(chain_in.pos + 1'b1);
	end

	assign shift_up = chain_out.found && !chain_out.abort;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= stkt_pkg::EMPTY_ENTRY;
		end else if (cmd.remove && shift_up) begin
			entry_q <= next_entry;
		end else if (cmd.place) begin
			if (chain_in.placed) begin
				entry_q <= prev_entry;
			end else if (worse) begin
				entry_q.name  <= cmd.name;
				entry_q.score <= cmd.score;
			end
		end
	end

endmodule

/* design/sorted_topk_unique_key_table_core.sv */
// ----------------------------------------------------------------------------
// sorted_topk_unique_key_table_core
// Sorted top-k table of named scores, one entry per name, lower is better.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid/item_ready) carries one transaction: op selects
//   insert (name_head/name_tail/score) or read (read_slot). Result channel
//   (result_valid/result_ready) returns exactly one transaction per item.
//   Passes: an accepted item runs a removal pass, then a placement pass,
//   over the cell row; result_valid rises when the placement pass fires.
//   The next item is taken only in idle or as that placement pass fires.
//   Reset: asynchronous, every slot becomes empty ("---", score 999999).
//   Stall: the result sits in an output register; while it waits the next
//   item is still taken and its removal pass runs, but its placement pass
//   (which also loads the output register) holds until result_ready.
//   save_request follows inserted: raise a table write when it is set.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_topk_unique_key_table_core (
	input  logic        clk,
	input  logic        arst_n,
	// item channel
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        op,
	input  logic [63:0] name_head,
	input  logic [55:0] name_tail,
	input  logic [19:0] score,
	input  logic [2:0]  read_slot,
	// result channel
	output logic        result_valid,
	input  logic        result_ready,
	output logic        inserted,
	output logic [2:0]  rank,
	output logic        replaced_own,
	output logic        save_request,
	output logic [63:0] entry_name_head,
	output logic [55:0] entry_name_tail,
	output logic [19:0] entry_score
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_REMOVE = 2'd1;
	localparam logic [1:0] ST_PLACE  = 2'd2;

	logic [1:0] state_q;

	// captured item
	logic                           op_q;
	logic [stkt_pkg::NAME_W-1:0]    name_q;
	logic [stkt_pkg::SCORE_W-1:0]   score_q;
	logic [2:0]                     slot_q;
	logic [stkt_pkg::NAME_W-1:0]    norm_name;

	// outcome of the removal pass
	logic removed_q;
	logic abort_q;

	// result register
	logic        result_valid_q;
	logic        inserted_q;
	logic [2:0]  rank_q;
	logic        replaced_q;
	logic [63:0] rd_head_q;
	logic [55:0] rd_tail_q;
	logic [19:0] rd_score_q;

	logic accept;
	logic place_fire;
	logic placed_eff;

	stkt_pkg::stkt_cmd_t   cmd;
	stkt_pkg::stkt_entry_t entries [stkt_pkg::TABLE_SLOTS];
	stkt_pkg::stkt_chain_t chains  [stkt_pkg::TABLE_SLOTS+1];
	stkt_pkg::stkt_entry_t rd_entry;

	// ---- handshake -----------------------------------------------------
	// placement pass waits for a free output register
	assign place_fire = (state_q == ST_PLACE) && (!result_valid_q || result_ready);
	assign item_ready = (state_q == ST_IDLE) || place_fire;
	assign accept     = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) state_q <= ST_REMOVE;
				end
				ST_REMOVE: begin
					state_q <= ST_PLACE;
				end
				ST_PLACE: begin
					if (place_fire) state_q <= accept ? ST_REMOVE : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// ---- item capture, name normalized on the way in --------------------
	stkt_norm u_norm (
		.name_head (name_head),
		.name_tail (name_tail),
		.name      (norm_name)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			name_q  <= norm_name;
			score_q <= score;
			slot_q  <= read_slot;
		end
	end

	// ---- cell row ------------------------------------------------------
	// remove pass: first matching slot and everything behind it moves up
	// place pass: new entry goes before the first worse score, rest move down
	always_comb begin
		cmd.remove = (state_q == ST_REMOVE) && (op_q == stkt_pkg::OP_INSERT);
		cmd.place  = place_fire && (op_q == stkt_pkg::OP_INSERT) && !abort_q;
		cmd.name   = name_q;
		cmd.score  = score_q;
	end

	assign chains[0] = '0;

	for (genvar g = 0; g < stkt_pkg::TABLE_SLOTS; g++) begin : g_cell
		stkt_pkg::stkt_entry_t prev_e;
		stkt_pkg::stkt_entry_t next_e;

		if (g == 0) begin : g_first
			assign prev_e = stkt_pkg::EMPTY_ENTRY;
		end else begin : g_mid_prev
			assign prev_e = entries[g-1];
		end

		// last slot refills empty on removal
		if (g == stkt_pkg::TABLE_SLOTS - 1) begin : g_last
			assign next_e = stkt_pkg::EMPTY_ENTRY;
		end else begin : g_mid_next
			assign next_e = entries[g+1];
		end

		stkt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.chain_in   (chains[g]),
			.entry      (entries[g]),
			.chain_out  (chains[g+1])
		);
	end

	// removal outcome: abort when the stored entry of that name is not worse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			removed_q <= 1'b0;
			abort_q   <= 1'b0;
		end else if (state_q == ST_REMOVE) begin
			removed_q <= (op_q == stkt_pkg::OP_INSERT) &&
			             chains[stkt_pkg::TABLE_SLOTS].found &&
			             !chains[stkt_pkg::TABLE_SLOTS].abort;
			abort_q   <= (op_q == stkt_pkg::OP_INSERT) &&
			             chains[stkt_pkg::TABLE_SLOTS].found &&
			             chains[stkt_pkg::TABLE_SLOTS].abort;
		end
	end

	assign placed_eff = cmd.place && chains[stkt_pkg::TABLE_SLOTS].placed;

	// read port: slots beyond the table read as empty
	always_comb begin
		rd_entry = stkt_pkg::EMPTY_ENTRY;
		for (int i = 0; i < stkt_pkg::TABLE_SLOTS; i++) begin
			if (int'(slot_q) == i) rd_entry = entries[i];
		end
	end

	// ---- result register -------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (place_fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (place_fire) begin
			if (op_q == stkt_pkg::OP_READ) begin
				inserted_q <= 1'b0;
				rank_q     <= 3'd0;
				replaced_q <= 1'b0;
				rd_head_q  <= rd_entry.name[63:0];
				rd_tail_q  <= rd_entry.name[119:64];
				rd_score_q <= rd_entry.score;
			end else begin
				inserted_q <= placed_eff || removed_q;
				rank_q     <= placed_eff ? 3'(chains[stkt_pkg::TABLE_SLOTS].pos) : 3'd0;
				replaced_q <= removed_q;
				rd_head_q  <= '0;
				rd_tail_q  <= '0;
				rd_score_q <= '0;
			end
		end
	end

	assign result_valid    = result_valid_q;
	assign inserted        = inserted_q;
	assign rank            = rank_q;
	assign replaced_own    = replaced_q;
	assign save_request    = inserted_q;
	assign entry_name_head = rd_head_q;
	assign entry_name_tail = rd_tail_q;
	assign entry_score     = rd_score_q;

endmodule

/* design/stkt_checker.sv */
// ----------------------------------------------------------------------------
// stkt_checker
// Port-level checks for the sorted top-k key table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sorted_topk_unique_key_table_core_assert.svh"

module stkt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        result_valid,
	input logic        result_ready,
	input logic        inserted,
	input logic [2:0]  rank,
	input logic        replaced_own,
	input logic        save_request,
	input logic [19:0] entry_score
);

	// one item at a time: the removal pass follows every accepted transaction
	`STKT_ASSERT_NEXT(a_busy_after_accept, item_valid && item_ready, !item_ready, "item_ready high during removal pass")

	// once an item is taken and its removal and placement passes have run, a result is on the port
	`STKT_ASSERT_NOW(a_result_due, $past(item_valid && item_ready, 3), result_valid, "no result two cycles after accept")

	`STKT_ASSERT_NOW(a_result_flags, result_valid, (save_request == inserted) && (inserted || ((rank == 3'd0) && !replaced_own)), "result flags inconsistent")

	`STKT_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(inserted) && $stable(rank) && $stable(entry_score), "stalled result changed")

endmodule

bind sorted_topk_unique_key_table_core stkt_checker u_stkt_checker (.*);

/* tb/sorted_topk_table_checker.sv */
// ----------------------------------------------------------------------------
// sorted_topk_table_checker
// Watches both channels, keeps its own copy of the table and compares each
// result transaction against the predicted one, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_topk_table_checker
	import stkt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	input  logic        item_ready,
	input  logic        op,
	input  logic [63:0] name_head,
	input  logic [55:0] name_tail,
	input  logic [19:0] score,
	input  logic [2:0]  read_slot,
	input  logic        result_valid,
	input  logic        result_ready,
	input  logic        inserted,
	input  logic [2:0]  rank,
	input  logic        replaced_own,
	input  logic        save_request,
	input  logic [63:0] entry_name_head,
	input  logic [55:0] entry_name_tail,
	input  logic [19:0] entry_score,
	output int          errors,
	output int          pending,
	output int          read_count,
	output int          placed_count,
	output int          replaced_count,
	output int          kept_count
);

	typedef struct packed {
		logic               inserted;
		logic [2:0]         rank;
		logic               replaced_own;
		logic               save_request;
		logic [63:0]        head;
		logic [55:0]        tail;
		logic [SCORE_W-1:0] score;
	} table_result_t;

	logic [NAME_W-1:0]  slot_name  [TABLE_SLOTS];
	logic [SCORE_W-1:0] slot_score [TABLE_SLOTS];
	table_result_t      result_q   [$];

	task automatic update_table(input logic op_i, input logic [NAME_W-1:0] raw,
			input logic [SCORE_W-1:0] sc, input logic [2:0] slot);
		table_result_t     r;
		logic [NAME_W-1:0] nm;
		logic [7:0]        b;
		bit                ended;
		int                hit;
		int                pos;
		r = '0;
		if (op_i == OP_READ) begin
			read_count++;
			if (slot < TABLE_SLOTS) begin
				r.head  = slot_name[slot][63:0];
				r.tail  = slot_name[slot][119:64];
				r.score = slot_score[slot];
			end else begin
				r.head  = EMPTY_NAME[63:0];
				r.tail  = EMPTY_NAME[119:64];
				r.score = EMPTY_SCORE;
			end
		end else begin
			// a name ends at its first zero byte
			nm    = '0;
			ended = 0;
			for (int i = 0; i < NAME_BYTES; i++) begin
				b = raw[8*i +: 8];
				if (b == 8'h00)
					ended = 1;
				if (!ended)
					nm[8*i +: 8] = b;
			end
			hit = -1;
			for (int i = 0; i < TABLE_SLOTS; i++)
				if (hit < 0 && slot_score[i] < EMPTY_SCORE && slot_name[i] == nm)
					hit = i;
			if (hit >= 0 && sc >= slot_score[hit]) begin
				kept_count++;
			end else begin
				if (hit >= 0) begin
					for (int j = hit; j + 1 < TABLE_SLOTS; j++) begin
						slot_name[j]  = slot_name[j+1];
						slot_score[j] = slot_score[j+1];
					end
					slot_name[TABLE_SLOTS-1]  = EMPTY_NAME;
					slot_score[TABLE_SLOTS-1] = EMPTY_SCORE;
					r.replaced_own = 1'b1;
					replaced_count++;
				end
				pos = -1;
				for (int i = 0; i < TABLE_SLOTS; i++)
					if (pos < 0 && sc < slot_score[i])
						pos = i;
				if (pos >= 0) begin
					for (int i = TABLE_SLOTS - 1; i > pos; i--) begin
						slot_name[i]  = slot_name[i-1];
						slot_score[i] = slot_score[i-1];
					end
					slot_name[pos]  = nm;
					slot_score[pos] = sc;
					r.rank = 3'(pos);
					placed_count++;
				end else begin
					kept_count += (hit < 0);
				end
				r.inserted     = (pos >= 0) || (hit >= 0);
				r.save_request = r.inserted;
			end
		end
		result_q.push_back(r);
	endtask

	task automatic check_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		table_result_t w;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				slot_name[i]  = EMPTY_NAME;
				slot_score[i] = EMPTY_SCORE;
			end
			result_q.delete();
			errors         = 0;
			pending        = 0;
			read_count     = 0;
			placed_count   = 0;
			replaced_count = 0;
			kept_count     = 0;
		end else begin
			// results first: the item taken this edge cannot answer yet
			if (result_valid && result_ready) begin
				if (result_q.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected, expected none, got %0h",
						$time, {inserted, rank, replaced_own, entry_score});
				end else begin
					w = result_q.pop_front();
					check_field("inserted", 64'(w.inserted), 64'(inserted));
					check_field("rank", 64'(w.rank), 64'(rank));
					check_field("replaced_own", 64'(w.replaced_own), 64'(replaced_own));
					check_field("save_request", 64'(w.save_request), 64'(save_request));
					check_field("entry_name_head", w.head, entry_name_head);
					check_field("entry_name_tail", 64'(w.tail), 64'(entry_name_tail));
					check_field("entry_score", 64'(w.score), 64'(entry_score));
				end
			end
			if (item_valid && item_ready)
				update_table(op, {name_tail, name_head}, score, read_slot);
			pending = result_q.size();
		end
	end

endmodule

/* tb/sorted_topk_unique_key_table_core_test.sv */
// ----------------------------------------------------------------------------
// sorted_topk_unique_key_table_core_test
// Drives insert and read transactions into the sorted top-k table, with
// random gaps and back pressure; a side checker predicts and compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_topk_unique_key_table_core_test;
	import stkt_pkg::*;

	localparam int RANDOM_ITEMS = 750;
	// quiet cycles allowed before the run is called hung; the long
	// receiver hold-off is well under this
	localparam int IDLE_LIMIT   = 2000;
	localparam int HOLD_CYCLES  = 48;

	logic        clk             = 1'b0;
	logic        arst_n          = 1'b0;
	logic        item_valid      = 1'b0;
	logic        item_ready;
	logic        op              = OP_INSERT;
	logic [63:0] name_head       = '0;
	logic [55:0] name_tail       = '0;
	logic [19:0] score           = '0;
	logic [2:0]  read_slot       = '0;
	logic        result_valid;
	logic        result_ready    = 1'b0;
	logic        inserted;
	logic [2:0]  rank;
	logic        replaced_own;
	logic        save_request;
	logic [63:0] entry_name_head;
	logic [55:0] entry_name_tail;
	logic [19:0] entry_score;

	int errors;
	int pending;
	int read_count;
	int placed_count;
	int replaced_count;
	int kept_count;
	int idle_cycles = 0;

	// short names that repeat often, so own-entry matches are common
	string name_words [6] = '{"RED", "BLUE", "GREEN", "CYAN", "GOLD", "IRON"};

	always #2 clk = ~clk;

	sorted_topk_unique_key_table_core dut (.*);

	sorted_topk_table_checker table_checker (.*);

	// Word from the pool; with junk set, random bytes follow the terminator,
	// which the block must ignore both for matching and for storing.
	function automatic logic [NAME_W-1:0] pool_name(input int idx, input bit junk);
		logic [NAME_W-1:0] nm;
		string             w;
		nm = '0;
		w  = name_words[idx];
		for (int i = 0; i < w.len(); i++)
			nm[8*i +: 8] = w[i];
		if (junk)
			for (int i = w.len() + 1; i < NAME_BYTES; i++)
				nm[8*i +: 8] = 8'($urandom);
		return nm;
	endfunction

	function automatic logic [NAME_W-1:0] random_name();
		logic [NAME_W-1:0] nm;
		nm = '0;
		case ($urandom_range(0, 9))
			6: nm = EMPTY_NAME;
			7: begin
				// all 15 bytes in use
				for (int i = 0; i < NAME_BYTES; i++)
					nm[8*i +: 8] = 8'($urandom_range(1, 255));
			end
			8: nm = NAME_W'({$urandom, $urandom, $urandom, $urandom});
			9: begin
				for (int i = 0; i < 2; i++)
					nm[8*i +: 8] = 8'($urandom_range(65, 67));
			end
			default: nm = pool_name($urandom_range(0, 5), $urandom_range(0, 1));
		endcase
		return nm;
	endfunction

	function automatic logic [SCORE_W-1:0] random_score();
		logic [SCORE_W-1:0] sc;
		case ($urandom_range(0, 9))
			6: sc = SCORE_W'($urandom_range(0, EMPTY_SCORE - 1));
			7: sc = SCORE_W'($urandom_range(EMPTY_SCORE, 20'hFFFFF));
			8: sc = SCORE_W'($urandom);
			9: begin
				case ($urandom_range(0, 3))
					0: sc = '0;
					1: sc = SCORE_W'(EMPTY_SCORE - 1);
					2: sc = EMPTY_SCORE;
					default: sc = '1;
				endcase
			end
			// small range: plenty of ties and near-ties
			default: sc = SCORE_W'($urandom_range(0, 40));
		endcase
		return sc;
	endfunction

	// Offer one transaction and hold it until the block takes it.
	task automatic send_item(input logic op_i, input logic [NAME_W-1:0] nm,
			input logic [SCORE_W-1:0] sc, input logic [2:0] slot, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 3);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		op         <= op_i;
		name_head  <= nm[63:0];
		name_tail  <= nm[119:64];
		score      <= sc;
		read_slot  <= slot;
		do @(posedge clk); while (!(item_valid && item_ready));
	endtask

	// Result side: random stalls, a stretch with none, and two
	// long hold-offs so the output register fills and item_ready drops.
	initial begin : result_sink
		int gap;
		int taken;
		taken = 0;
		wait (arst_n);
		forever begin
			gap = $urandom_range(0, 3);
			if (taken >= 200 && taken < 300)
				gap = 0;
			if (taken == 60 || taken == 500)
				gap = HOLD_CYCLES;
			if (gap != 0) begin
				result_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!(result_valid && result_ready));
			taken++;
		end
	end

	// Hang detector: counts cycles in which neither channel moves.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout after %0d quiet cycles, %0d results outstanding",
					idle_cycles, pending);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [NAME_W-1:0] nm;
		bit                no_gap;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// blank table reads back as empty slots
		send_item(OP_READ, EMPTY_NAME, '0, 3'd0, 1'b0);
		send_item(OP_READ, EMPTY_NAME, '1, 3'd7, 1'b0);
		// first entry, then equal and worse scores for the same name: no change
		send_item(OP_INSERT, pool_name(0, 0), 20'd100, 3'd0, 1'b0);
		send_item(OP_INSERT, pool_name(0, 0), 20'd100, 3'd0, 1'b0);
		send_item(OP_INSERT, pool_name(0, 0), 20'd150, 3'd0, 1'b0);
		// better score: own entry removed and re-placed
		send_item(OP_INSERT, pool_name(0, 0), 20'd50, 3'd0, 1'b0);
		// tie with an existing score lands behind it
		send_item(OP_INSERT, pool_name(1, 0), 20'd50, 3'd0, 1'b0);
		// "---" must not match the empty slots
		send_item(OP_INSERT, EMPTY_NAME, 20'd10, 3'd0, 1'b0);
		// empty name with the best possible score
		send_item(OP_INSERT, '0, '0, 3'd0, 1'b0);
		// all-ones 15-byte name at the worst score that still enters
		send_item(OP_INSERT, '1, SCORE_W'(EMPTY_SCORE - 1), 3'd7, 1'b0);
		// scores at or above the empty mark never enter
		send_item(OP_INSERT, pool_name(4, 1), EMPTY_SCORE, 3'd0, 1'b0);
		send_item(OP_INSERT, pool_name(4, 0), '1, 3'd0, 1'b0);
		// junk after the terminator still matches the stored name
		send_item(OP_INSERT, pool_name(0, 1), 20'd20, 3'd0, 1'b0);
		// overfill: eight fresh names push the tail out
		for (int i = 0; i < 8; i++) begin
			nm          = '0;
			nm[7:0]     = 8'h4E;
			nm[15:8]    = 8'h30 + 8'(i);
			send_item(OP_INSERT, nm, 20'(i + 1), 3'd0, 1'b0);
		end
		send_item(OP_READ, '1, '0, 3'd0, 1'b0);
		send_item(OP_READ, '0, '0, 3'd3, 1'b0);
		send_item(OP_READ, '0, '0, 3'd7, 1'b0);

		// --- random part ---
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// back-to-back stretch, no sender gaps
			no_gap = (i >= 300 && i < 400);
			if ($urandom_range(0, 3) == 0)
				send_item(OP_READ, random_name(), random_score(),
					3'($urandom_range(0, 7)), no_gap);
			else
				send_item(OP_INSERT, random_name(), random_score(),
					3'($urandom_range(0, 7)), no_gap);
		end
		item_valid <= 1'b0;

		// drain: let the last transaction reach the checker, then wait it out
		@(posedge clk);
		wait (pending == 0);
		repeat (8) @(posedge clk);

		$display("covered %0d reads and %0d inserts: %0d placed, %0d own entries replaced,",
			read_count, placed_count + kept_count, placed_count, replaced_count);
		$display("%0d inserts left the table unchanged; receiver stalls and input back pressure",
			kept_count);
		if (errors == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

/* files.f */
+incdir+design
design/stkt_pkg.sv
design/stkt_norm.sv
design/stkt_cell.sv
design/sorted_topk_unique_key_table_core.sv
design/stkt_checker.sv
tb/sorted_topk_table_checker.sv
tb/sorted_topk_unique_key_table_core_test.sv
